// ----- rtl/pl0ts_pkg.sv -----
// ----------------------------------------------------------------------------
// pl0ts_pkg: shared types and constants of the PL/0 token scanner
// Result word layout, token kinds, symbol and error codes, keyword table.
// ----------------------------------------------------------------------------
package pl0ts_pkg;

  localparam int KW_COUNT   = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_SYMBOL  = 5'd2;
  localparam logic [4:0] KIND_KW_BASE = 5'd3;
  localparam logic [4:0] KIND_EOF     = 5'd16;
  localparam logic [4:0] KIND_ERROR   = 5'd17;

  localparam logic [3:0] SYM_NONE       = 4'd0;
  localparam logic [3:0] SYM_STAR       = 4'd0;
  localparam logic [3:0] SYM_PLUS       = 4'd1;
  localparam logic [3:0] SYM_MINUS      = 4'd2;
  localparam logic [3:0] SYM_SLASH      = 4'd3;
  localparam logic [3:0] SYM_EQUAL      = 4'd4;
  localparam logic [3:0] SYM_SEMI       = 4'd5;
  localparam logic [3:0] SYM_COMMA      = 4'd6;
  localparam logic [3:0] SYM_PERIOD     = 4'd7;
  localparam logic [3:0] SYM_LPAREN     = 4'd8;
  localparam logic [3:0] SYM_RPAREN     = 4'd9;
  localparam logic [3:0] SYM_ASSIGN     = 4'd10;
  localparam logic [3:0] SYM_LESS       = 4'd11;
  localparam logic [3:0] SYM_LESS_EQ    = 4'd12;
  localparam logic [3:0] SYM_NOT_EQ     = 4'd13;
  localparam logic [3:0] SYM_GREATER    = 4'd14;
  localparam logic [3:0] SYM_GREATER_EQ = 4'd15;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_COLON = 2'd1;
  localparam logic [1:0] ERR_CHAR  = 2'd2;

  // Keyword spellings, first character in the low byte, unused bytes zero.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0074_736e_6f63,  // const
    64'h0000_0000_0072_6176,  // var
    64'h6e6f_6974_636e_7566,  // function
    64'h0000_006e_6967_6562,  // begin
    64'h0000_0000_0064_6e65,  // end
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6e65_6874,  // then
    64'h0000_0065_6c69_6877,  // while
    64'h0000_0000_0000_6f64,  // do
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0065_7469_7277,  // write
    64'h006e_6c65_7469_7277,  // writeln
    64'h0000_0000_0064_646f   // odd
  };

  localparam logic [15:0] KW_LEN [KW_COUNT] = '{
    16'd5, 16'd3, 16'd8, 16'd5, 16'd3, 16'd2, 16'd4,
    16'd5, 16'd2, 16'd6, 16'd5, 16'd7, 16'd3
  };

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [3:0]  symbol_code;
    logic [31:0] number_value;
    logic        number_overflow;
    logic [63:0] lexeme_head;
    logic [15:0] lexeme_length;
    logic [23:0] line_number;
    logic [15:0] column;
    logic [1:0]  error_code;
    logic        last;
  } tok_result_t;

  typedef struct packed {
    logic [1:0]  cnt;
    tok_result_t r0;
    tok_result_t r1;
  } scan_push_t;

endpackage

// ----- rtl/pl0ts_if.sv -----
// ----------------------------------------------------------------------------
// pl0ts_if: source and result channels of the PL/0 token scanner
// Valid/ready channels; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface pl0ts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;
  logic       file_end;

  modport source (output valid, char_code, line_end, file_end, input ready);
  modport sink (input valid, char_code, line_end, file_end, output ready);
endinterface

interface pl0ts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [3:0]  symbol_code;
  logic [31:0] number_value;
  logic        number_overflow;
  logic [63:0] lexeme_head;
  logic [15:0] lexeme_length;
  logic [23:0] line_number;
  logic [15:0] column;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, token_kind, symbol_code, number_value, number_overflow,
                  lexeme_head, lexeme_length, line_number, column, error_code, last,
                  input ready);
  modport sink (input valid, token_kind, symbol_code, number_value, number_overflow,
                lexeme_head, lexeme_length, line_number, column, error_code, last,
                output ready);
endinterface

// ----- rtl/pl0ts_kw_match.sv -----
// ----------------------------------------------------------------------------
// pl0ts_kw_match: keyword lookup
// Compares a finished identifier against all keywords in parallel.
// ----------------------------------------------------------------------------
module pl0ts_kw_match import pl0ts_pkg::*; (
  input  logic [63:0] head,
  input  logic [15:0] len,
  output logic [4:0]  kind
);

  always_comb begin
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (len == KW_LEN[k] && head == KW_TEXT[k]) begin
        kind = 5'(KIND_KW_BASE + 5'(k));
      end
    end
  end

endmodule

// ----- rtl/pl0ts_scan.sv -----
// ----------------------------------------------------------------------------
// pl0ts_scan: scanner state and one-word step logic
// Holds the token under construction and the line and column counters, and
// produces up to two result words for every accepted source word.
// ----------------------------------------------------------------------------
module pl0ts_scan import pl0ts_pkg::*; #(
  parameter int HEAD_CHARS  = 8,
  parameter int NUMBER_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_code,
  input  logic       line_end,
  input  logic       file_end,
  output scan_push_t push
);

  localparam int IDX_W = $clog2(HEAD_CHARS);

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_IDENT   = 7'b0000010,
    MODE_NUMBER  = 7'b0000100,
    MODE_COMMENT = 7'b0001000,
    MODE_COLON   = 7'b0010000,
    MODE_LESS    = 7'b0100000,
    MODE_GREATER = 7'b1000000
  } mode_t;

  mode_t                        mode_r, mode_nxt;
  logic [HEAD_CHARS-1:0][7:0]   head_r, head_nxt, head_ext;
  logic [15:0]                  len_r, len_nxt, len_inc;
  logic [NUMBER_BITS-1:0]       acc_r, acc_nxt, acc_step;
  logic                         sat_r, sat_nxt, sat_step;
  logic [LINE_BITS-1:0]         line_r, line_nxt, line_inc;
  logic [COLUMN_BITS-1:0]       col_r, col_nxt, col_inc;

  logic [NUMBER_BITS+3:0]       acc_mul;
  logic                         acc_ovf;
  logic [63:0]                  acc_w;
  logic [31:0]                  line_w, line_inc_w, col_w, col_inc_w;
  logic                         is_alpha, is_digit, is_space, is_alnum;
  logic                         sym_hit;
  logic [3:0]                   sym_code;
  logic [4:0]                   ident_kind;
  logic                         pend_v, a_v, b_v;
  tok_result_t                  pend_res, res_a, res_b;

  function automatic tok_result_t mk_res(input logic [4:0]  kind,
                                         input logic [3:0]  sym,
                                         input logic [31:0] num,
                                         input logic        ovf,
                                         input logic [63:0] head,
                                         input logic [15:0] len,
                                         input logic [23:0] line,
                                         input logic [15:0] col,
                                         input logic [1:0]  err);
    tok_result_t r;
    r.token_kind      = kind;
    r.symbol_code     = sym;
    r.number_value    = num;
    r.number_overflow = ovf;
    r.lexeme_head     = head;
    r.lexeme_length   = len;
    r.line_number     = line;
    r.column          = col;
    r.error_code      = err;
    r.last            = 1'b0;
    return r;
  endfunction

  pl0ts_kw_match u_kw_match (
    .head (head_r[7:0]),
    .len  (len_r),
    .kind (ident_kind)
  );

  assign is_alpha = (char_code >= "a" && char_code <= "z") ||
                    (char_code >= "A" && char_code <= "Z");
  assign is_digit = char_code >= "0" && char_code <= "9";
  assign is_space = char_code == " " || (char_code >= 8'd9 && char_code <= 8'd13);
  assign is_alnum = is_alpha || is_digit;

  assign col_inc  = (col_r == '1) ? col_r : col_r + COLUMN_BITS'(1);
  assign line_inc = (line_r == '1) ? line_r : line_r + LINE_BITS'(1);
  assign len_inc  = (len_r == '1) ? len_r : len_r + 16'd1;

  assign acc_w      = 64'(acc_r);
  assign line_w     = 32'(line_r);
  assign line_inc_w = 32'(line_inc);
  assign col_w      = 32'(col_r);
  assign col_inc_w  = 32'(col_inc);

  // Ten times the value plus the new digit; any carry into the top bits saturates.
  assign acc_mul  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                    {NUMBER_BITS'(0), char_code[3:0]};
  assign acc_ovf  = |acc_mul[NUMBER_BITS+3:NUMBER_BITS];
  assign acc_step = sat_r ? acc_r : (acc_ovf ? '1 : acc_mul[NUMBER_BITS-1:0]);
  assign sat_step = sat_r | acc_ovf;

  always_comb begin
    head_ext = head_r;
    if (len_r < 16'(HEAD_CHARS)) begin
      head_ext[len_r[IDX_W-1:0]] = char_code;
    end
  end

  always_comb begin
    sym_hit  = 1'b1;
    sym_code = SYM_NONE;
    unique case (char_code)
      "*": sym_code = SYM_STAR;
      "+": sym_code = SYM_PLUS;
      "-": sym_code = SYM_MINUS;
      "/": sym_code = SYM_SLASH;
      "=": sym_code = SYM_EQUAL;
      ";": sym_code = SYM_SEMI;
      ",": sym_code = SYM_COMMA;
      ".": sym_code = SYM_PERIOD;
      "(": sym_code = SYM_LPAREN;
      ")": sym_code = SYM_RPAREN;
      default: sym_hit = 1'b0;
    endcase
  end

  always_comb begin
    pend_v   = 1'b1;
    pend_res = mk_res(KIND_SYMBOL, SYM_NONE, 32'd0, 1'b0, head_r[7:0], len_r,
                      line_w[23:0], col_w[15:0], ERR_NONE);
    unique case (mode_r)
      MODE_IDENT:   pend_res.token_kind = ident_kind;
      MODE_NUMBER: begin
        pend_res.token_kind      = KIND_NUMBER;
        pend_res.number_value    = acc_w[31:0];
        pend_res.number_overflow = sat_r;
      end
      MODE_LESS:    pend_res.symbol_code = SYM_LESS;
      MODE_GREATER: pend_res.symbol_code = SYM_GREATER;
      MODE_COLON: begin
        pend_res.token_kind = KIND_ERROR;
        pend_res.error_code = ERR_COLON;
      end
      default:      pend_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    head_nxt = head_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    a_v      = 1'b0;
    b_v      = 1'b0;
    res_a    = pend_res;
    res_b    = mk_res(KIND_ERROR, SYM_NONE, 32'd0, 1'b0, 64'(char_code), 16'd1,
                      line_w[23:0], col_inc_w[15:0], ERR_CHAR);
    if (step) begin
      if (line_end || file_end) begin
        a_v = pend_v;
        if (pend_v) begin
          mode_nxt = MODE_IDLE;
          head_nxt = '0;
          len_nxt  = '0;
          acc_nxt  = '0;
          sat_nxt  = 1'b0;
        end
        if (line_end) begin
          line_nxt = line_inc;
          col_nxt  = '0;
        end
        if (file_end) begin
          b_v      = 1'b1;
          res_b    = mk_res(KIND_EOF, SYM_NONE, 32'd0, 1'b0, 64'd0, 16'd0,
                            line_end ? line_inc_w[23:0] : line_w[23:0], 16'd0, ERR_NONE);
          mode_nxt = MODE_IDLE;
          head_nxt = '0;
          len_nxt  = '0;
          acc_nxt  = '0;
          sat_nxt  = 1'b0;
          line_nxt = LINE_BITS'(1);
          col_nxt  = '0;
        end
      end else if (mode_r == MODE_COMMENT) begin
        col_nxt = col_inc;
        if (char_code == "}") begin
          mode_nxt = MODE_IDLE;
        end
      end else if ((mode_r == MODE_IDENT && is_alnum) ||
                   (mode_r == MODE_NUMBER && is_digit)) begin
        col_nxt  = col_inc;
        head_nxt = head_ext;
        len_nxt  = len_inc;
        if (mode_r == MODE_NUMBER) begin
          acc_nxt = acc_step;
          sat_nxt = sat_step;
        end
      end else if ((mode_r == MODE_LESS && (char_code == "=" || char_code == ">")) ||
                   (mode_r == MODE_GREATER && char_code == "=") ||
                   (mode_r == MODE_COLON && char_code == "=")) begin
        col_nxt  = col_inc;
        a_v      = 1'b1;
        res_a    = mk_res(KIND_SYMBOL, SYM_ASSIGN, 32'd0, 1'b0, head_ext[7:0], len_inc,
                          line_w[23:0], col_inc_w[15:0], ERR_NONE);
        if (mode_r == MODE_LESS) begin
          res_a.symbol_code = (char_code == "=") ? SYM_LESS_EQ : SYM_NOT_EQ;
        end else if (mode_r == MODE_GREATER) begin
          res_a.symbol_code = SYM_GREATER_EQ;
        end
        mode_nxt = MODE_IDLE;
        head_nxt = '0;
        len_nxt  = '0;
        acc_nxt  = '0;
        sat_nxt  = 1'b0;
      end else begin
        // The pending token ends here and the word starts afresh from an empty token.
        a_v      = pend_v;
        col_nxt  = col_inc;
        mode_nxt = MODE_IDLE;
        head_nxt = '0;
        len_nxt  = '0;
        acc_nxt  = '0;
        sat_nxt  = 1'b0;
        if (is_space) begin
          mode_nxt = MODE_IDLE;
        end else if (is_alpha) begin
          head_nxt[0] = char_code;
          len_nxt     = 16'd1;
          mode_nxt    = MODE_IDENT;
        end else if (char_code == "0") begin
          b_v   = 1'b1;
          res_b = mk_res(KIND_NUMBER, SYM_NONE, 32'd0, 1'b0, 64'(char_code), 16'd1,
                         line_w[23:0], col_inc_w[15:0], ERR_NONE);
        end else if (is_digit) begin
          head_nxt[0] = char_code;
          len_nxt     = 16'd1;
          acc_nxt     = NUMBER_BITS'(char_code[3:0]);
          mode_nxt    = MODE_NUMBER;
        end else if (char_code == "{") begin
          mode_nxt = MODE_COMMENT;
        end else if (char_code == ":" || char_code == "<" || char_code == ">") begin
          head_nxt[0] = char_code;
          len_nxt     = 16'd1;
          if (char_code == ":") begin
            mode_nxt = MODE_COLON;
          end else if (char_code == "<") begin
            mode_nxt = MODE_LESS;
          end else begin
            mode_nxt = MODE_GREATER;
          end
        end else if (sym_hit) begin
          b_v   = 1'b1;
          res_b = mk_res(KIND_SYMBOL, sym_code, 32'd0, 1'b0, 64'(char_code), 16'd1,
                         line_w[23:0], col_inc_w[15:0], ERR_NONE);
        end else begin
          b_v = 1'b1;
        end
      end
    end
  end

  always_comb begin
    push = '0;
    if (a_v) begin
      push.r0      = res_a;
      push.r0.last = !b_v;
      push.r1      = res_b;
      push.r1.last = b_v;
      push.cnt     = b_v ? 2'd2 : 2'd1;
    end else if (b_v) begin
      push.r0      = res_b;
      push.r0.last = 1'b1;
      push.cnt     = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      head_r <= '0;
      len_r  <= '0;
      acc_r  <= '0;
      sat_r  <= 1'b0;
      line_r <= LINE_BITS'(1);
      col_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      head_r <= head_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      sat_r  <= sat_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  a_idle_token_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE || mode_r == MODE_COMMENT) |-> (len_r == '0 && head_r == '0))
    else $error("token buffer not empty between tokens");

  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (acc_r == '1 && mode_r == MODE_NUMBER))
    else $error("saturated number without maximum value");

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && file_end) |=> (mode_r == MODE_IDLE && line_r == LINE_BITS'(1) &&
                            col_r == '0 && len_r == '0))
    else $error("end of file did not return scanner to its start state");

endmodule

// ----- rtl/pl0ts_out_fifo.sv -----
// ----------------------------------------------------------------------------
// pl0ts_out_fifo: result queue
// Small register queue that takes up to two result words per cycle and
// hands out one per handshake.
// ----------------------------------------------------------------------------
module pl0ts_out_fifo import pl0ts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  scan_push_t  push,
  output logic        room,
  output logic        valid,
  input  logic        ready,
  output tok_result_t head
);

  tok_result_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]     count_r, count_nxt;
  logic                    pop;

  assign valid      = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign pop        = valid && ready;
  assign room       = count_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);
  assign wr_ptr_p1  = wr_ptr_r + FIFO_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.cnt);
  assign rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
  assign count_nxt  = count_r + (FIFO_PTR_W+1)'(push.cnt) - (FIFO_PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("results pushed without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> count_r == $past(count_r) - (FIFO_PTR_W+1)'(1))
    else $error("result queue count lost a word");

endmodule

// ----- rtl/pl0_token_scanner_core.sv -----
// ----------------------------------------------------------------------------
// pl0_token_scanner_core: streaming PL/0 lexer
// Takes one source character or line/file event per word and returns tokens.
// ----------------------------------------------------------------------------
// The scanner accepts one source word per clock cycle while the queue has room and writes
// the tokens it causes, up to two, into a four-word result queue in the same cycle, so a
// token is available in the cycle after the word that completes it. The input is ready
// whenever the queue holds two words or fewer; a source word that yields two
// tokens therefore costs two output handshakes, and the sustained rate is one
// word per cycle as long as results are taken as fast as they are produced.
module pl0_token_scanner_core import pl0ts_pkg::*; #(
  parameter int HEAD_CHARS  = 8,
  parameter int NUMBER_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input logic           clk,
  input logic           rst_n,
  pl0ts_in_if.sink      in_if,
  pl0ts_out_if.source   out_if
);

  scan_push_t  push;
  tok_result_t head;
  logic        room;
  logic        step;

  assign in_if.ready = room;
  assign step        = in_if.valid && room;

  pl0ts_scan #(
    .HEAD_CHARS  (HEAD_CHARS),
    .NUMBER_BITS (NUMBER_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_code (in_if.char_code),
    .line_end  (in_if.line_end),
    .file_end  (in_if.file_end),
    .push      (push)
  );

  pl0ts_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (room),
    .valid (out_if.valid),
    .ready (out_if.ready),
    .head  (head)
  );

  assign out_if.token_kind      = head.token_kind;
  assign out_if.symbol_code     = head.symbol_code;
  assign out_if.number_value    = head.number_value;
  assign out_if.number_overflow = head.number_overflow;
  assign out_if.lexeme_head     = head.lexeme_head;
  assign out_if.lexeme_length   = head.lexeme_length;
  assign out_if.line_number     = head.line_number;
  assign out_if.column          = head.column;
  assign out_if.error_code      = head.error_code;
  assign out_if.last            = head.last;

endmodule
